FILE: rtl/core/bppr_pkg.sv
// ----------------------------------------------------------------------------
// bppr_pkg
// Shared types and constants of the boiler pressure power regulator.
// ----------------------------------------------------------------------------
package bppr_pkg;

  localparam int PRESSURE_WIDTH_DEF = 10;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 10;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_DUAL_SENSOR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_RULES   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_PRESS  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_PRESS    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_POWER     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_POWER     = 3'd5;

  localparam logic [7:0] MAX_POWER_RST = 8'd100;

  localparam logic [6:0] INNER_OFFSET  = 7'd65;
  localparam logic [6:0] PWR_CAP_HIGH  = 7'd80;
  localparam logic [6:0] PWR_BACKOFF   = 7'd70;
  localparam logic [6:0] PWR_FULL      = 7'd100;
  localparam logic [6:0] PWR_LOW_SUBST = 7'd25;
  localparam logic [6:0] PWR_LOW_LIMIT = 7'd20;
  localparam logic [15:0] PERIOD_FAST  = 16'd6;
  localparam logic [15:0] PERIOD_SLOW  = 16'd5;
  localparam logic [3:0] BAND_PHASE    = 4'd10;
  localparam logic [3:0] BAND_SINGLE   = 4'd5;
  localparam logic [1:0] HYST_PHASE    = 2'd2;

  localparam int DIVIDEND_W = 16;
  localparam int DIVISOR_W  = 8;

  typedef struct packed {
    logic       dual_sensor;
    logic       phase_change_rules;
    logic [9:0] target_pressure;
    logic [9:0] stop_pressure;
    logic [7:0] max_power;
    logic [6:0] min_power;
  } cfg_t;

  typedef struct packed {
    logic [6:0] power_level;
    logic       fast_ramp_flag;
    logic       pending_fast;
    logic       pending_slow;
  } loop_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/bppr_in_if.sv
// ----------------------------------------------------------------------------
// bppr_in_if
// Input channel: one control tick per beat.
// ----------------------------------------------------------------------------
interface bppr_in_if #(
  parameter int PRESSURE_WIDTH = bppr_pkg::PRESSURE_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic [PRESSURE_WIDTH-1:0] outlet_pressure;
  logic [PRESSURE_WIDTH-1:0] inner_pressure;
  logic                      fast_step_pulse;
  logic                      slow_step_pulse;
  logic                      sample_pulse;
  logic                      flame_on;

  modport source (output valid, outlet_pressure, inner_pressure, fast_step_pulse,
                  slow_step_pulse, sample_pulse, flame_on, input ready);
  modport sink   (input valid, outlet_pressure, inner_pressure, fast_step_pulse,
                  slow_step_pulse, sample_pulse, flame_on, output ready);
endinterface

FILE: rtl/core/bppr_out_if.sv
// ----------------------------------------------------------------------------
// bppr_out_if
// Result channel: new power setting and status per beat.
// ----------------------------------------------------------------------------
interface bppr_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  power_percent;
  logic        overpressure_stop;
  logic        fast_ramp;
  logic [15:0] change_period;

  modport source (output valid, power_percent, overpressure_stop, fast_ramp,
                  change_period, input ready);
  modport sink   (input valid, power_percent, overpressure_stop, fast_ramp,
                  change_period, output ready);
endinterface

FILE: rtl/core/bppr_div.sv
// ----------------------------------------------------------------------------
// bppr_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bppr_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [bppr_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [bppr_pkg::DIVISOR_W-1:0]   divisor,
  output logic [bppr_pkg::DIVIDEND_W-1:0]  quotient,
  output bppr_pkg::div_stat_t              stat
);
  localparam int NW = bppr_pkg::DIVIDEND_W;
  localparam int DW = bppr_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[NW-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits back in DW bits
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DW'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dsr_r <= divisor;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/core/bppr_rules.sv
// ----------------------------------------------------------------------------
// bppr_rules
// Power balance step: ramp, back-off, limits and overpressure flag.
// ----------------------------------------------------------------------------
module bppr_rules #(
  parameter int PRESSURE_WIDTH = bppr_pkg::PRESSURE_WIDTH_DEF
) (
  input  bppr_pkg::cfg_t             cfg,
  input  logic [PRESSURE_WIDTH-1:0]  outlet,
  input  logic [PRESSURE_WIDTH-1:0]  regulated,
  input  logic [15:0]                change_period,
  input  bppr_pkg::loop_state_t      cur,
  output bppr_pkg::loop_state_t      nxt,
  output logic                       overpressure
);
  // wide enough for the set point plus offset and for R plus the band
  localparam int CW = ((PRESSURE_WIDTH > 11) ? PRESSURE_WIDTH : 11) + 1;

  logic [CW-1:0] pv, rv, tv, mv, sv, offv;
  logic [7:0]    tp, now, amax;
  logic          pf, ps, flag;

  always_comb begin
    pv   = CW'(outlet);
    rv   = CW'(regulated);
    tv   = CW'(cfg.target_pressure);
    offv = cfg.dual_sensor ? CW'(bppr_pkg::INNER_OFFSET) : '0;
    mv   = tv + offv;
    sv   = CW'(cfg.stop_pressure) + offv;
    pf   = cur.pending_fast;
    ps   = cur.pending_slow;
    flag = cur.fast_ramp_flag;
    tp   = {1'b0, cur.power_level};

    // below set point
    if (pv < tv && rv < mv) begin
      if (change_period > bppr_pkg::PERIOD_FAST) flag = 1'b1;
      if (change_period <= bppr_pkg::PERIOD_SLOW) flag = 1'b0;
      if (flag) begin
        if (pf) begin pf = 1'b0; tp = tp + 8'd1; end
      end else if (ps) begin
        ps = 1'b0;
        tp = tp + 8'd1;
      end
    end

    if (rv == mv) begin
      if (cur.power_level > bppr_pkg::PWR_CAP_HIGH) tp = {1'b0, bppr_pkg::PWR_CAP_HIGH};
      flag = 1'b1;
    end

    if (!cfg.phase_change_rules) begin
      if (pv > tv) begin
        if (rv > mv) begin
          if (cur.power_level > bppr_pkg::PWR_CAP_HIGH) tp = {1'b0, bppr_pkg::PWR_BACKOFF};
          if (pf) begin pf = 1'b0; tp = (tp != 8'd0) ? tp - 8'd1 : 8'd0; end
        end else begin
          // in or out of the dead band, P above set point always backs off
          if (pf) begin pf = 1'b0; tp = (tp != 8'd0) ? tp - 8'd1 : 8'd0; end
        end
      end else if (rv > mv) begin
        if (pf) begin pf = 1'b0; tp = (tp != 8'd0) ? tp - 8'd1 : 8'd0; end
      end
    end else begin
      if (pv >= tv) begin
        if (rv > mv) begin
          if (cur.power_level > bppr_pkg::PWR_CAP_HIGH) tp = {1'b0, bppr_pkg::PWR_BACKOFF};
          if (pf) begin pf = 1'b0; tp = (tp != 8'd0) ? tp - 8'd1 : 8'd0; end
        end else if (pv >= tv + CW'(bppr_pkg::HYST_PHASE)) begin
          if (pf) begin pf = 1'b0; tp = (tp != 8'd0) ? tp - 8'd1 : 8'd0; end
        end else if (rv + CW'(bppr_pkg::BAND_PHASE) <= mv) begin
          if (pf) begin pf = 1'b0; tp = tp + 8'd1; end
        end
      end else if (rv > mv) begin
        if (pf) begin pf = 1'b0; tp = (tp != 8'd0) ? tp - 8'd1 : 8'd0; end
      end
    end

    if (cfg.max_power >= {1'b0, bppr_pkg::PWR_FULL}) amax = {1'b0, bppr_pkg::PWR_FULL};
    else if (cfg.max_power < {1'b0, bppr_pkg::PWR_LOW_LIMIT})
      amax = {1'b0, bppr_pkg::PWR_LOW_SUBST};
    else amax = cfg.max_power;

    now = (tp > amax) ? amax : tp;
    if (now < {1'b0, cfg.min_power}) now = {1'b0, cfg.min_power};

    nxt.power_level    = now[6:0];
    nxt.fast_ramp_flag = flag | (now[6:0] >= bppr_pkg::PWR_BACKOFF);
    nxt.pending_fast   = pf;
    nxt.pending_slow   = ps;

    overpressure = (rv >= sv) || (pv >= CW'(cfg.stop_pressure));
  end

endmodule

FILE: rtl/core/boiler_pressure_power_regulator_core.sv
// ----------------------------------------------------------------------------
// boiler_pressure_power_regulator_core
// Burner power regulator driven by one beat per control tick.
// ----------------------------------------------------------------------------
// in_ch carries one control tick per beat: pressures, step/sample pulses and
// flame status. out_ch returns one beat per tick with the new power percent,
// the overpressure stop request, the fast ramp flag and the change period.
// cfg_we/cfg_addr/cfg_wdata write the settings; write them only while idle.
//
// An accepted beat moves to the rule step, whose result is committed to
// the output register once that register is free. When a sample pulse with
// flame present sees the pressure move, the beat first passes the division
// step: the elapsed seconds are divided by the change, one quotient bit per
// cycle in the serial divider. One tick is in flight at a time; the next is
// taken as soon as the result of the last is parked in the output register.
//
// Reset clears the loop state and the settings (max power returns to 100).
// If the receiver stalls, the finished result holds in the output register;
// a following tick is taken and worked, then waits for the register to free.
// ----------------------------------------------------------------------------
module boiler_pressure_power_regulator_core #(
  parameter int PRESSURE_WIDTH = bppr_pkg::PRESSURE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  bppr_in_if.sink                              in_ch,
  bppr_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [bppr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [bppr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  localparam int PW = PRESSURE_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RULE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  bppr_pkg::cfg_t        cfg_r;
  bppr_pkg::loop_state_t loop_r, loop_nxt, rule_nxt;
  logic [PW-1:0]         last_r, last_nxt;
  logic [15:0]           sec_r, sec_nxt, period_r, period_nxt;
  logic [PW-1:0]         outlet_r, reg_r;

  logic [6:0]            o_power_r;
  logic                  o_stop_r, o_fast_r, o_valid_r;
  logic [15:0]           o_period_r;

  logic                  accept, commit, div_start, overpressure;
  logic [PW-1:0]         r_in, diff;
  logic [7:0]            divisor;
  logic [15:0]           sec_inc, quotient;
  bppr_pkg::div_stat_t   div_stat;

  assign accept = in_ch.valid && in_ch.ready && (state_r == S_IDLE);
  assign commit = (state_r == S_RULE) && (!o_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == S_IDLE);

  assign r_in    = cfg_r.dual_sensor ? in_ch.inner_pressure : in_ch.outlet_pressure;
  assign sec_inc = (sec_r == 16'hFFFF) ? sec_r : sec_r + 16'd1;
  assign diff    = (r_in > last_r) ? r_in - last_r : last_r - r_in;
  assign divisor = (diff > PW'(255)) ? 8'hFF : diff[7:0];

  // speed detection at the input beat, then division wait and rule commit
  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    sec_nxt    = sec_r;
    period_nxt = period_r;
    loop_nxt   = loop_r;
    div_start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          loop_nxt.pending_fast = loop_r.pending_fast | in_ch.fast_step_pulse;
          loop_nxt.pending_slow = loop_r.pending_slow | in_ch.slow_step_pulse;
          state_nxt = S_RULE;
          if (in_ch.sample_pulse) begin
            if (in_ch.flame_on) begin
              sec_nxt = sec_inc;
              if (r_in != last_r) begin
                last_nxt  = r_in;
                sec_nxt   = '0;
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end else begin
              last_nxt   = r_in;
              sec_nxt    = '0;
              period_nxt = '0;
            end
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          period_nxt = quotient;
          state_nxt  = S_RULE;
        end
      end
      S_RULE: begin
        if (commit) begin
          loop_nxt  = rule_nxt;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  bppr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sec_inc),
    .divisor  (divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  bppr_rules #(
    .PRESSURE_WIDTH (PW)
  ) u_rules (
    .cfg           (cfg_r),
    .outlet        (outlet_r),
    .regulated     (reg_r),
    .change_period (period_r),
    .cur           (loop_r),
    .nxt           (rule_nxt),
    .overpressure  (overpressure)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      outlet_r <= in_ch.outlet_pressure;
      reg_r    <= r_in;
    end
    if (commit) begin
      o_power_r  <= rule_nxt.power_level;
      o_stop_r   <= overpressure;
      o_fast_r   <= rule_nxt.fast_ramp_flag;
      o_period_r <= period_r;
    end
    if (!rst_n) begin
      state_r   <= S_IDLE;
      loop_r    <= '0;
      last_r    <= '0;
      sec_r     <= '0;
      period_r  <= '0;
      o_valid_r <= 1'b0;
      cfg_r     <= '{dual_sensor: 1'b0, phase_change_rules: 1'b0,
                     target_pressure: '0, stop_pressure: '0,
                     max_power: bppr_pkg::MAX_POWER_RST, min_power: '0};
    end else begin
      state_r  <= state_nxt;
      loop_r   <= loop_nxt;
      last_r   <= last_nxt;
      sec_r    <= sec_nxt;
      period_r <= period_nxt;
      if (commit) o_valid_r <= 1'b1;
      else if (out_ch.ready) o_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          bppr_pkg::REG_DUAL_SENSOR:  cfg_r.dual_sensor        <= cfg_wdata[0];
          bppr_pkg::REG_PHASE_RULES:  cfg_r.phase_change_rules <= cfg_wdata[0];
          bppr_pkg::REG_TARGET_PRESS: cfg_r.target_pressure    <= cfg_wdata;
          bppr_pkg::REG_STOP_PRESS:   cfg_r.stop_pressure      <= cfg_wdata;
          bppr_pkg::REG_MAX_POWER:    cfg_r.max_power          <= cfg_wdata[7:0];
          bppr_pkg::REG_MIN_POWER:    cfg_r.min_power          <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid             = o_valid_r;
  assign out_ch.power_percent     = o_power_r;
  assign out_ch.overpressure_stop = o_stop_r;
  assign out_ch.fast_ramp         = o_fast_r;
  assign out_ch.change_period     = o_period_r;

endmodule

FILE: rtl/core/bppr_checker.sv
// ----------------------------------------------------------------------------
// bppr_checker
// Port-level checks on the regulator core, attached by bind.
// ----------------------------------------------------------------------------
module bppr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] power_percent,
  input logic       fast_ramp
);

  // a stalled result beat holds its power value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(power_percent))
    else $error("result beat dropped or changed while stalled");

  // one tick in flight: the input closes right after a beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is still in work");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // power at or above 70 percent always forces the fast ramp
  a_fast_at_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !fast_ramp |-> power_percent < 7'd70)
    else $error("high power reported without fast ramp");

endmodule

bind boiler_pressure_power_regulator_core bppr_checker u_bppr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .power_percent (out_ch.power_percent),
  .fast_ramp     (out_ch.fast_ramp)
);
